>>> rtl/lhf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhf_pkg
// Shared constants for the line header filter: register indexes, reset
// values, widths and the line feed code.
// ----------------------------------------------------------------------------
package lhf_pkg;

   localparam int LINE_DEPTH_DFLT = 64;
   localparam int HDR_BYTES       = 7;
   localparam int HDR_WORD_W      = 8 * HDR_BYTES;
   localparam int HDR_LEN_W       = 3;
   localparam int CSR_INDEX_W     = 1;

   localparam logic [7:0]            LF_CODE        = 8'd10;
   localparam logic [HDR_WORD_W-1:0] HDR_WORD_RESET = 56'd24295141054566436;
   localparam logic [HDR_LEN_W-1:0]  HDR_LEN_RESET  = 3'd7;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HEADER_WORD = 1'b0,
      CSR_HEADER_LEN  = 1'b1
   } csr_index_type;

endpackage

>>> rtl/lhf_line_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhf_line_ram
// Line store: one write port, one read port, registered read data that holds
// until the next read.
// ----------------------------------------------------------------------------
module lhf_line_ram #(
   parameter int LINE_DEPTH = lhf_pkg::LINE_DEPTH_DFLT
) (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [$clog2(LINE_DEPTH)-1:0] wr_addr,
   input  logic [7:0]                    wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
   output logic [7:0]                    rd_data
);

   logic [7:0] mem [LINE_DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/lhf_dump.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lhf_dump
// Reads a finished line out of the line store and streams it on the result
// channel through a prefetch slot and an output register.
// ----------------------------------------------------------------------------
module lhf_dump #(
   parameter int LINE_DEPTH = lhf_pkg::LINE_DEPTH_DFLT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [$clog2(LINE_DEPTH)-1:0] end_addr,
   output logic                          rd_en,
   output logic [$clog2(LINE_DEPTH)-1:0] rd_addr,
   input  logic [7:0]                    rd_data,
   output logic                          busy,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_last_byte
);
   import lhf_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);

   logic          reading_ff;
   logic [AW-1:0] rd_addr_ff;
   logic [AW-1:0] end_addr_ff;
   logic          pending_ff;
   logic          out_valid_ff;
   logic [7:0]    out_byte_ff;
   logic          load;

   assign load  = pending_ff && (!out_valid_ff || rsp_ready);
   assign rd_en = reading_ff && (!pending_ff || load);

   always_ff @(posedge clock) begin
      if (reset) begin
         reading_ff   <= 1'b0;
         pending_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (start) begin
            reading_ff <= 1'b1;
         end else if (rd_en && rd_addr_ff == end_addr_ff) begin
            reading_ff <= 1'b0;
         end
         if (rd_en) begin
            pending_ff <= 1'b1;
         end else if (load) begin
            pending_ff <= 1'b0;
         end
         if (load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         rd_addr_ff  <= '0;
         end_addr_ff <= end_addr;
      end else if (rd_en) begin
         rd_addr_ff <= rd_addr_ff + AW'(1);
      end
      if (load) begin
         out_byte_ff <= rd_data;
      end
   end

   // Only the closing line feed of a line can hold the line feed code.
   assign rd_addr       = rd_addr_ff;
   assign busy          = reading_ff || pending_ff || out_valid_ff;
   assign rsp_valid     = out_valid_ff;
   assign rsp_out_byte  = out_byte_ff;
   assign rsp_last_byte = (out_byte_ff == LF_CODE);

endmodule

>>> rtl/line_header_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_header_filter
// Gathers received bytes into lines and forwards lines whose header matches.
// ----------------------------------------------------------------------------
// Each received word is written into the line store while its header position
// is checked. When a line feed arrives and the line matched, the line is read
// back from the store and sent out one word per cycle while the consumer is
// ready, each word passing through the read register of the store and the
// output register, the line feed itself marked as last. No input is taken
// until the last word of the line has been delivered. Up to LINE_DEPTH - 1
// words are kept per line; later words other than the line feed are dropped.
// The store needs no clearing after reset.
module line_header_filter #(
   parameter int LINE_DEPTH = lhf_pkg::LINE_DEPTH_DFLT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_rx_byte,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_last_byte,
   input  logic                           csr_we,
   input  logic [lhf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lhf_pkg::HDR_WORD_W-1:0]  csr_wdata
);
   import lhf_pkg::*;

   localparam int AW = $clog2(LINE_DEPTH);
   localparam int CW = AW + 1;
   localparam logic [AW-1:0] FILL_MAX = AW'(LINE_DEPTH - 1);

   logic [HDR_WORD_W-1:0] header_word_ff;
   logic [HDR_LEN_W-1:0]  header_len_ff;
   logic [AW-1:0]         fill_ff;
   logic [AW-1:0]         fill_in;
   logic                  header_ok_ff;
   logic                  header_ok_in;
   logic                  accept;
   logic                  is_lf;
   logic                  wr_en;
   logic                  start;
   logic                  in_header;
   logic [7:0]            hdr_byte;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [7:0]            rd_data;
   logic                  busy;

   assign accept    = req_valid && req_ready;
   assign is_lf     = (req_rx_byte == LF_CODE);
   assign hdr_byte  = header_word_ff[8 * fill_ff[2:0] +: 8];
   assign in_header = CW'(fill_ff) < CW'(header_len_ff);
   assign wr_en     = accept && (is_lf || fill_ff != FILL_MAX);
   assign start     = accept && is_lf && header_ok_ff
                      && CW'(fill_ff) >= CW'(header_len_ff);
   assign req_ready = !busy;

   always_comb begin
      fill_in      = fill_ff;
      header_ok_in = header_ok_ff;
      if (accept) begin
         if (is_lf) begin
            fill_in      = '0;
            header_ok_in = 1'b1;
         end else if (fill_ff != FILL_MAX) begin
            fill_in = fill_ff + AW'(1);
            if (in_header && req_rx_byte != hdr_byte) begin
               header_ok_in = 1'b0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         header_word_ff <= HDR_WORD_RESET;
         header_len_ff  <= HDR_LEN_RESET;
         fill_ff        <= '0;
         header_ok_ff   <= 1'b1;
      end else begin
         fill_ff      <= fill_in;
         header_ok_ff <= header_ok_in;
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_HEADER_WORD: header_word_ff <= csr_wdata;
               CSR_HEADER_LEN:  header_len_ff  <= csr_wdata[HDR_LEN_W-1:0];
               default: ;
            endcase
         end
      end
   end

   lhf_line_ram #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (fill_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   lhf_dump #(
      .LINE_DEPTH(LINE_DEPTH)
   ) u_dump (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .end_addr      (fill_ff),
      .rd_en         (rd_en),
      .rd_addr       (rd_addr),
      .rd_data       (rd_data),
      .busy          (busy),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte)
   );

`ifndef SYNTH
   // Intake and dump never overlap.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input accepted while a line is being sent");

   // The line ends with its last word.
   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last_byte |=> !rsp_valid)
      else $error("word sent after the end of a line");

   // A line feed resets the fill count and the header match flag.
   a_lf_clears: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_rx_byte == LF_CODE |=> fill_ff == '0 && header_ok_ff)
      else $error("line state not cleared after a line feed");
`endif

endmodule

>>> bench/line_header_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_header_checker
// Watches the line header filter's ports, predicts the forwarded lines and
// compares every returned word against the oldest predicted one.
// ----------------------------------------------------------------------------
module line_header_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [7:0]                      req_rx_byte,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [7:0]                      rsp_out_byte,
   input  logic                            rsp_last_byte,
   input  logic                            csr_we,
   input  logic [lhf_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [lhf_pkg::HDR_WORD_W-1:0]  csr_wdata,
   output int                              fail_count,
   output int                              words_pending,
   output int                              lines_seen,
   output int                              lines_forwarded,
   output int                              words_checked
);
   import lhf_pkg::*;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } line_word_type;

   localparam int DEPTH = LINE_DEPTH_DFLT;

   logic [7:0]            line_buf [DEPTH];
   int unsigned           line_fill;
   bit                    line_hdr_ok;
   logic [HDR_WORD_W-1:0] hdr_word;
   logic [HDR_LEN_W-1:0]  hdr_len;
   line_word_type         words_due [$];
   int                    n_fail;
   int                    n_lines;
   int                    n_fwd;
   int                    n_checked;

   initial begin
      fail_count      = 0;
      words_pending   = 0;
      lines_seen      = 0;
      lines_forwarded = 0;
      words_checked   = 0;
      n_fail          = 0;
      n_lines         = 0;
      n_fwd           = 0;
      n_checked       = 0;
   end

   task automatic gather_rx(input logic [7:0] b);
      int unsigned k;
      if (b != LF_CODE) begin
         if (line_fill < DEPTH - 1) begin
            if (line_fill < hdr_len && b != hdr_word[8*line_fill +: 8]) begin
               line_hdr_ok = 1'b0;
            end
            line_buf[line_fill] = b;
            line_fill++;
         end
      end else begin
         line_buf[line_fill] = b;
         n_lines++;
         if (line_hdr_ok && line_fill >= hdr_len) begin
            n_fwd++;
            for (k = 0; k <= line_fill; k++) begin
               words_due.push_back('{data: line_buf[k], last: (k == line_fill)});
            end
         end
         line_fill   = 0;
         line_hdr_ok = 1'b1;
      end
   endtask

   always @(posedge clock) begin
      line_word_type exp_w;
      if (reset) begin
         words_due.delete();
         line_fill   = 0;
         line_hdr_ok = 1'b1;
         hdr_word    = HDR_WORD_RESET;
         hdr_len     = HDR_LEN_RESET;
      end else begin
         if (req_valid && req_ready) begin
            gather_rx(req_rx_byte);
         end
         if (rsp_valid && rsp_ready) begin
            if (words_due.size() == 0) begin
               n_fail++;
               if (n_fail <= 10) begin
                  $display("unexpected result word %02h last %0b",
                           rsp_out_byte, rsp_last_byte);
               end
            end else begin
               exp_w = words_due.pop_front();
               n_checked++;
               if (exp_w.data !== rsp_out_byte || exp_w.last !== rsp_last_byte) begin
                  n_fail++;
                  if (n_fail <= 10) begin
                     $display("result word %0d: expected %02h last %0b, got %02h last %0b",
                              n_checked, exp_w.data, exp_w.last, rsp_out_byte,
                              rsp_last_byte);
                  end
               end
            end
         end
         if (csr_we) begin
            case (csr_index)
               CSR_HEADER_WORD: hdr_word = csr_wdata;
               CSR_HEADER_LEN:  hdr_len = csr_wdata[HDR_LEN_W-1:0];
               default: ;
            endcase
         end
      end
      fail_count      <= n_fail;
      words_pending   <= words_due.size();
      lines_seen      <= n_lines;
      lines_forwarded <= n_fwd;
      words_checked   <= n_checked;
   end

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the line header filter: directed lines for the
// corner cases, then random lines under three idle mixes and a long hold-off.
// ----------------------------------------------------------------------------
module tb;
   import lhf_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int CYCLE_LIMIT = 200000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   logic [7:0]             req_rx_byte = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_last_byte;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [HDR_WORD_W-1:0]  csr_wdata = '0;

   int fail_count;
   int words_pending;
   int lines_seen;
   int lines_forwarded;
   int words_checked;

   int                    send_idle_pct = 33;
   int                    recv_idle_pct = 83;
   int                    words_sent = 0;
   int                    cycle_count = 0;
   logic [HDR_WORD_W-1:0] cur_word = HDR_WORD_RESET;
   logic [HDR_LEN_W-1:0]  cur_len = HDR_LEN_RESET;
   logic                  hold_req = 1'b0;
   logic                  hold_ack = 1'b0;
   int                    hold_left = 0;

   always #2 clock = ~clock;

   line_header_filter u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_rx_byte   (req_rx_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_last_byte (rsp_last_byte),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata)
   );

   line_header_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_last_byte   (rsp_last_byte),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .fail_count      (fail_count),
      .words_pending   (words_pending),
      .lines_seen      (lines_seen),
      .lines_forwarded (lines_forwarded),
      .words_checked   (words_checked)
   );

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_req != hold_ack) begin
         hold_ack  <= hold_req;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      words_sent++;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_header(input logic [HDR_WORD_W-1:0] w, input logic [HDR_LEN_W-1:0] l);
      csr_we    <= 1'b1;
      csr_index <= CSR_HEADER_WORD;
      csr_wdata <= w;
      @(posedge clock);
      csr_index <= CSR_HEADER_LEN;
      csr_wdata <= HDR_WORD_W'(l);
      @(posedge clock);
      csr_we   <= 1'b0;
      cur_word = w;
      cur_len  = l;
   endtask

   task automatic send_header_bytes(input int count, input int bad_pos);
      logic [7:0] b;
      logic [7:0] alt;
      for (int p = 0; p < count; p++) begin
         b = cur_word[8*p +: 8];
         if (p == bad_pos) begin
            do alt = 8'($urandom); while (alt == b || alt == LF_CODE);
            b = alt;
         end
         send_byte(b);
      end
   endtask

   task automatic send_body(input int n);
      logic [7:0] b;
      for (int i = 0; i < n; i++) begin
         do b = 8'($urandom); while (b == LF_CODE);
         send_byte(b);
      end
   endtask

   task automatic send_random_line();
      int kind;
      int n;
      kind = $urandom_range(99);
      n    = ($urandom_range(15) == 0) ? $urandom_range(56, 70) : $urandom_range(8);
      if (kind < 55 || cur_len == 0) begin
         send_header_bytes(cur_len, -1);
         send_body(n);
      end else if (kind < 75) begin
         send_header_bytes(cur_len, $urandom_range(cur_len - 1));
         send_body(n);
      end else if (kind < 85) begin
         send_header_bytes($urandom_range(cur_len - 1), -1);
      end else begin
         repeat ($urandom_range(12)) send_byte(8'($urandom));
      end
      send_byte(LF_CODE);
   endtask

   initial begin
      logic [HDR_WORD_W-1:0] w;
      logic [HDR_LEN_W-1:0]  l;
      int                    budget;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset header, with the byte extremes in the body.
      send_header_bytes(HDR_LEN_RESET, -1);
      send_byte(8'hFF);
      send_byte(8'h00);
      send_byte(LF_CODE);

      // A zero header length passes even an empty line.
      settle();
      set_header(HDR_WORD_RESET, 3'd0);
      send_byte(LF_CODE);

      // Short line, then a mismatched second header byte.
      settle();
      set_header(56'h4241, 3'd2);
      send_byte(8'h41);
      send_byte(LF_CODE);
      send_byte(8'h41);
      send_byte(8'h58);
      send_byte(LF_CODE);

      // A line feed inside the header can only pass when the length excludes it.
      settle();
      set_header(56'h0A41, 3'd2);
      send_byte(8'h41);
      send_byte(LF_CODE);
      settle();
      set_header(56'h0A41, 3'd1);
      send_byte(8'h41);
      send_byte(LF_CODE);

      // The header changes in the middle of a line.
      settle();
      set_header(56'h41, 3'd1);
      send_byte(8'h41);
      settle();
      set_header(56'h42, 3'd1);
      send_byte(8'h43);
      send_byte(LF_CODE);

      for (int ph = 0; ph < 3; ph++) begin
         for (int sub = 0; sub < 2; sub++) begin
            settle();
            if (sub == 0) begin
               send_idle_pct = (ph == 0) ? 33 : (ph == 1) ? 83 : 0;
               recv_idle_pct <= (ph == 0) ? 83 : (ph == 1) ? 33 : 0;
            end
            w = HDR_WORD_W'({$urandom, $urandom});
            case (ph * 2 + sub)
               0:       begin w = '1; l = 3'd7; end
               1:       begin w = '0; l = 3'd0; end
               2:       l = 3'd7;
               3:       l = HDR_LEN_W'($urandom_range(1, 6));
               4:       l = HDR_LEN_W'($urandom_range(7));
               default: begin w = '0; l = 3'd4; end
            endcase
            set_header(w, l);
            if (ph == 0 && sub == 0) begin
               send_header_bytes(cur_len, -1);
               send_body(70);
               send_byte(LF_CODE);
            end
            if (ph == 1 && sub == 0) begin
               hold_req <= ~hold_req;
            end
            budget = words_sent + 5;
            while (words_sent < budget) send_random_line();
         end
      end

      settle();
      $display("Sent %0d words in %0d lines, %0d lines forwarded, %0d result words checked.",
               words_sent, lines_seen, lines_forwarded, words_checked);
      $display("Header lengths 0 to 7, three idle mixes and a long receiver hold-off were used.");
      if (fail_count == 0 && words_pending == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

>>> filelist.f
rtl/lhf_pkg.sv
rtl/lhf_line_ram.sv
rtl/lhf_dump.sv
rtl/line_header_filter.sv
bench/line_header_checker.sv
bench/tb.sv
